// File: design/rbcp_pkg.sv
// Shared types and constants for the raster-to-block chroma pack block.
// No dependencies; every other design file refers to this package by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package rbcp_pkg;

    // Default sizes of the band store geometry.
    localparam int BLOCK_DEF            = 8;
    localparam int MAX_WIDTH_BLOCKS_DEF = 128;

    // Fixed by the register and field widths.
    localparam int MAX_HEIGHT_BLOCKS = 4096;
    localparam int PIX_W             = 8;
    localparam int CFG_WIDTH_W       = 8;
    localparam int CFG_HEIGHT_W      = 13;
    localparam int CFG_DATA_W        = 13;
    localparam int BAND_CNT_W        = 12;

    typedef enum logic [0:0] {
        FUNC_PUSH  = 1'b0,
        FUNC_DRAIN = 1'b1
    } t_func;

    typedef enum logic [0:0] {
        CFG_WIDTH_IN_BLOCKS  = 1'b0,
        CFG_HEIGHT_IN_BLOCKS = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_func             func;
        logic [PIX_W-1:0]  luma_in;
        logic [PIX_W-1:0]  blue_diff_in;
        logic [PIX_W-1:0]  red_diff_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]  luma_out;
        logic [PIX_W-1:0]  blue_diff_out;
        logic [PIX_W-1:0]  red_diff_out;
        logic              block_end;
        logic              image_end;
    } t_out_item;

endpackage

`default_nettype wire

// File: design/raster_to_block_chroma_pack.sv
// Top level of the raster-to-block reorder with packed 4:2:0 chroma.
// Depends on rbcp_pkg and rbcp_band_store.
//
// Usage: pixels arrive on the input channel (i_in_valid / o_in_ready / i_in_data)
// in raster order. A transaction with func PUSH writes one pixel into the write
// half of a ping-pong band store holding BLOCK image rows; a transaction with func
// DRAIN writes nothing. Every input transaction, of either kind, also reads one
// pending pixel of a finished band if there is one, and that pixel leaves on the
// output channel (o_out_valid / i_out_ready / o_out_data) in block order, with
// luma as stored and Cb/Cr packed into the top-left quadrant of each block.
// The configuration port takes width and height in blocks; write it only while
// the block is idle. Out-of-range values are clamped.
// Throughput: one input transaction per clock unless the output stalls. Each
// transaction is at most one store write and one read of each store array.
// The store read register is loaded at the accepting edge, and the output
// register is loaded from it when the read stage moves on.
// Stall: when the receiver holds i_out_ready low, the output register holds its
// transaction and the read stage can still take one more; only when both are full
// does o_in_ready drop. Reset clears all counters and sets both configuration
// registers to one; the store needs no clearing pass, so transactions flow at once.
`timescale 1ns / 1ps
`default_nettype none

module raster_to_block_chroma_pack #(
    parameter int BLOCK            = rbcp_pkg::BLOCK_DEF,
    parameter int MAX_WIDTH_BLOCKS = rbcp_pkg::MAX_WIDTH_BLOCKS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Input channel.
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire rbcp_pkg::t_in_item                   i_in_data,
    // Output channel.
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output rbcp_pkg::t_out_item                       o_out_data,
    // Configuration write port.
    input  wire logic                                 i_cfg_wr_en,
    input  wire rbcp_pkg::t_cfg_index                 i_cfg_index,
    input  wire logic [rbcp_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    // Geometry. The store address is {half, row, column} with power-of-two fields.
    localparam int RW       = $clog2(BLOCK);
    localparam int ROW_LEN  = BLOCK * MAX_WIDTH_BLOCKS;
    localparam int CW       = $clog2(ROW_LEN);
    localparam int HALF_LEN = BLOCK * ROW_LEN;
    localparam int PW       = $clog2(HALF_LEN + 1);
    localparam int WW       = $clog2(MAX_WIDTH_BLOCKS + 1);
    localparam int BKW      = (MAX_WIDTH_BLOCKS > 1) ? $clog2(MAX_WIDTH_BLOCKS) : 1;
    localparam int ADDR_W   = 1 + RW + CW;
    localparam int BCW      = rbcp_pkg::BAND_CNT_W;

    localparam logic [RW-1:0] B_LAST = RW'(BLOCK - 1);
    localparam logic [RW-1:0] B_HALF = RW'(BLOCK / 2);

    // Configuration registers.
    logic [rbcp_pkg::CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [rbcp_pkg::CFG_HEIGHT_W-1:0] r_cfg_height;

    // Write side counters.
    logic [CW-1:0] r_write_col,  n_write_col;
    logic [RW-1:0] r_write_row,  n_write_row;
    logic          r_write_half, n_write_half;

    // Read side counters. The position inside a block is kept as row and column.
    logic [BKW-1:0] r_read_block, n_read_block;
    logic [RW-1:0]  r_read_row,   n_read_row;
    logic [RW-1:0]  r_read_col,   n_read_col;
    logic           r_read_half,  n_read_half;
    logic [BCW-1:0] r_band,       n_band;
    logic [PW-1:0]  r_pending,    n_pending;

    // Read stage (store read data lives in the store) and output stage.
    logic                r_s1_valid;
    logic                r_s1_quad;
    logic                r_s1_bend;
    logic                r_s1_iend;
    logic                r_out_valid;
    rbcp_pkg::t_out_item r_out_data;

    // Effective sizes after clamping.
    logic [WW-1:0]  w_eff;
    logic [BKW-1:0] w_last;
    logic [BCW-1:0] h_last;
    logic [CW:0]    wpix;
    logic [CW-1:0]  wpix_last;
    logic [PW-1:0]  band_pix;

    // Per-transaction decode.
    logic              accept;
    logic              push;
    logic              has_read;
    logic              s1_advance;
    logic [BKW-1:0]    blk;
    logic [CW-1:0]     base;
    logic [CW-1:0]     luma_col;
    logic [CW-1:0]     chroma_col;
    logic [RW-1:0]     chroma_row;
    logic              quad;
    logic              bend;
    logic              blk_last;
    logic              iend;
    logic [CW-1:0]     wcol;
    logic              row_done;
    logic              band_done;
    logic [PW-1:0]     pend_dec;
    logic [PW:0]       pend_sum;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] luma_addr;
    logic [ADDR_W-1:0] chroma_addr;

    logic [rbcp_pkg::PIX_W-1:0]   rd_luma;
    logic [2*rbcp_pkg::PIX_W-1:0] rd_chroma;

    // ------------------------------------------------------------------
    // Configuration and clamped sizes.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= rbcp_pkg::CFG_WIDTH_W'(1);
            r_cfg_height <= rbcp_pkg::CFG_HEIGHT_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                rbcp_pkg::CFG_WIDTH_IN_BLOCKS: begin
                    r_cfg_width <= i_cfg_wdata[rbcp_pkg::CFG_WIDTH_W-1:0];
                end
                rbcp_pkg::CFG_HEIGHT_IN_BLOCKS: begin
                    r_cfg_height <= i_cfg_wdata[rbcp_pkg::CFG_HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH_BLOCKS)) begin
            w_eff = WW'(MAX_WIDTH_BLOCKS);
        end else begin
            w_eff = WW'(r_cfg_width);
        end

        if (r_cfg_height == '0) begin
            h_last = '0;
        end else if (32'(r_cfg_height) > 32'(rbcp_pkg::MAX_HEIGHT_BLOCKS)) begin
            h_last = BCW'(rbcp_pkg::MAX_HEIGHT_BLOCKS - 1);
        end else begin
            h_last = BCW'(r_cfg_height - rbcp_pkg::CFG_HEIGHT_W'(1));
        end
    end

    assign w_last    = BKW'(w_eff - WW'(1));
    assign wpix      = (CW + 1)'(w_eff * BLOCK);
    assign wpix_last = CW'(wpix - (CW + 1)'(1));
    assign band_pix  = PW'(wpix * BLOCK);

    // ------------------------------------------------------------------
    // Handshake. The read stage may refill whenever it moves on or is empty.
    // ------------------------------------------------------------------
    assign s1_advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign push       = (i_in_data.func == rbcp_pkg::FUNC_PUSH);
    assign has_read   = (r_pending != '0);

    // ------------------------------------------------------------------
    // Read address and flags for the pixel emitted by this transaction.
    // ------------------------------------------------------------------
    always_comb begin
        // A block index left beyond a narrowed width restarts at the left edge.
        blk        = (32'(r_read_block) < 32'(w_eff)) ? r_read_block : '0;
        base       = CW'(blk * BLOCK);
        luma_col   = base + CW'(r_read_col);
        chroma_col = base + CW'({r_read_col, 1'b0});
        chroma_row = RW'({r_read_row, 1'b0});
        quad       = (r_read_row < B_HALF) && (r_read_col < B_HALF);
        bend       = (r_read_row == B_LAST) && (r_read_col == B_LAST);
        blk_last   = (blk == w_last);
        iend       = bend && blk_last && (r_band == h_last);
    end

    assign luma_addr   = {r_read_half, r_read_row, luma_col};
    assign chroma_addr = {r_read_half, chroma_row, chroma_col};

    // ------------------------------------------------------------------
    // Next state of the read and write counters.
    // ------------------------------------------------------------------
    always_comb begin
        n_read_block = r_read_block;
        n_read_row   = r_read_row;
        n_read_col   = r_read_col;
        n_read_half  = r_read_half;
        n_band       = r_band;

        if (has_read) begin
            if (bend) begin
                n_read_row = '0;
                n_read_col = '0;
                if (blk_last) begin
                    n_read_block = '0;
                    n_read_half  = !r_read_half;
                    n_band       = iend ? '0 : r_band + BCW'(1);
                end else begin
                    n_read_block = blk + BKW'(1);
                end
            end else begin
                n_read_block = blk;
                if (r_read_col == B_LAST) begin
                    n_read_col = '0;
                    n_read_row = r_read_row + RW'(1);
                end else begin
                    n_read_col = r_read_col + RW'(1);
                end
            end
        end
    end

    always_comb begin
        // A column left beyond a narrowed width restarts at zero.
        wcol      = (32'(r_write_col) < 32'(wpix)) ? r_write_col : '0;
        row_done  = (wcol == wpix_last);
        band_done = push && row_done && (r_write_row == B_LAST);

        n_write_col  = r_write_col;
        n_write_row  = r_write_row;
        n_write_half = r_write_half;
        if (push) begin
            if (row_done) begin
                n_write_col = '0;
                if (r_write_row == B_LAST) begin
                    n_write_row  = '0;
                    n_write_half = !r_write_half;
                end else begin
                    n_write_row = r_write_row + RW'(1);
                end
            end else begin
                n_write_col = wcol + CW'(1);
            end
        end

        // The pending count saturates at one store half.
        pend_dec = has_read ? r_pending - PW'(1) : r_pending;
        pend_sum = {1'b0, pend_dec} + (band_done ? {1'b0, band_pix} : '0);
        if (32'(pend_sum) > 32'(HALF_LEN)) begin
            n_pending = PW'(HALF_LEN);
        end else begin
            n_pending = PW'(pend_sum);
        end
    end

    assign wr_addr = {r_write_half, r_write_row, wcol};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_col  <= '0;
            r_write_row  <= '0;
            r_write_half <= 1'b0;
            r_read_block <= '0;
            r_read_row   <= '0;
            r_read_col   <= '0;
            r_read_half  <= 1'b0;
            r_band       <= '0;
            r_pending    <= '0;
        end else if (accept) begin
            r_write_col  <= n_write_col;
            r_write_row  <= n_write_row;
            r_write_half <= n_write_half;
            r_read_block <= n_read_block;
            r_read_row   <= n_read_row;
            r_read_col   <= n_read_col;
            r_read_half  <= n_read_half;
            r_band       <= n_band;
            r_pending    <= n_pending;
        end
    end

    // ------------------------------------------------------------------
    // Band store. Reads are only issued on an accepted transaction, so the
    // read data stays put while the read stage waits.
    // ------------------------------------------------------------------
    rbcp_band_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk         (i_clk),
        .i_wr_en       (accept && push),
        .i_wr_addr     (wr_addr),
        .i_wr_luma     (i_in_data.luma_in),
        .i_wr_chroma   ({i_in_data.red_diff_in, i_in_data.blue_diff_in}),
        .i_rd_en       (accept && has_read),
        .i_luma_addr   (luma_addr),
        .i_chroma_addr (chroma_addr),
        .o_rd_luma     (rd_luma),
        .o_rd_chroma   (rd_chroma)
    );

    // ------------------------------------------------------------------
    // Read stage and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= has_read;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && has_read) begin
            r_s1_quad <= quad;
            r_s1_bend <= bend;
            r_s1_iend <= iend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_data.luma_out      <= rd_luma;
            r_out_data.blue_diff_out <= r_s1_quad ? rd_chroma[rbcp_pkg::PIX_W-1:0] : '0;
            r_out_data.red_diff_out  <= r_s1_quad ?
                                        rd_chroma[2*rbcp_pkg::PIX_W-1:rbcp_pkg::PIX_W] : '0;
            r_out_data.block_end     <= r_s1_bend;
            r_out_data.image_end     <= r_s1_iend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// File: design/rbcp_band_store.sv
// Ping-pong band store: a luma array and a chroma array sharing one write port.
// Each array has one registered read port. Depends on rbcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbcp_band_store #(
    parameter int ADDR_W = 14
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_wr_en,
    input  wire logic [ADDR_W-1:0]                i_wr_addr,
    input  wire logic [rbcp_pkg::PIX_W-1:0]       i_wr_luma,
    input  wire logic [2*rbcp_pkg::PIX_W-1:0]     i_wr_chroma,
    input  wire logic                             i_rd_en,
    input  wire logic [ADDR_W-1:0]                i_luma_addr,
    input  wire logic [ADDR_W-1:0]                i_chroma_addr,
    output logic      [rbcp_pkg::PIX_W-1:0]       o_rd_luma,
    output logic      [2*rbcp_pkg::PIX_W-1:0]     o_rd_chroma
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [rbcp_pkg::PIX_W-1:0]   r_luma_mem   [DEPTH];
    logic [2*rbcp_pkg::PIX_W-1:0] r_chroma_mem [DEPTH];

    // Reads return the contents from before a write in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_luma_mem[i_wr_addr] <= i_wr_luma;
        end
        if (i_rd_en) begin
            o_rd_luma <= r_luma_mem[i_luma_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_chroma_mem[i_wr_addr] <= i_wr_chroma;
        end
        if (i_rd_en) begin
            o_rd_chroma <= r_chroma_mem[i_chroma_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/rbcp_checker.sv
// Port-level checker for raster_to_block_chroma_pack, attached with a bind.
// Depends on rbcp_pkg and the top-level module.
`timescale 1ns / 1ps
`default_nettype none

module rbcp_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire rbcp_pkg::t_out_item i_out_data
);

    // A stalled output transaction holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output transaction changed while stalled");

    // Reset leaves no output pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // The image ends only on the last pixel of a block.
    a_image_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.image_end |-> i_out_data.block_end)
        else $error("image end without block end");

    // The last pixel of a block lies outside the chroma quadrant.
    a_end_no_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.block_end |->
            (i_out_data.blue_diff_out == '0) && (i_out_data.red_diff_out == '0))
        else $error("chroma present on the last pixel of a block");

endmodule

bind raster_to_block_chroma_pack rbcp_checker u_rbcp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

`default_nettype wire

// File: test/rbcp_block_order_checker.sv
// Checker for the raster-to-block chroma pack block: watches both channels and the register port.
// Keeps its own model of the band store, predicts each block-order pixel and compares it.
// Depends on rbcp_pkg for the payload and register index types.
`timescale 1ns / 1ps

module rbcp_block_order_checker
    import rbcp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire t_in_item              i_in_data,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire t_out_item             i_out_data,
    input  wire logic                  i_cfg_wr_en,
    input  wire t_cfg_index            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                         o_fail_count,
    output int                         o_outstanding
);

    localparam int unsigned BLK      = 8;
    localparam int unsigned MAX_W    = 128;
    localparam int unsigned ROW_LEN  = BLK * MAX_W;
    localparam int unsigned HALF_LEN = BLK * ROW_LEN;

    // Pixels are kept as {Cr, Cb, Y}.
    logic [23:0]    band_mem [0:2*HALF_LEN-1];
    int unsigned    wr_col, wr_row, wr_half;
    int unsigned    rd_blk, rd_pos, rd_half;
    int unsigned    pixels_waiting, band_idx;
    logic [7:0]     width_reg;
    logic [12:0]    height_reg;
    t_out_item      expected_pixels [$];
    int             mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic int unsigned store_addr(int unsigned half, int unsigned row,
                                               int unsigned col);
        return (half & 1) * HALF_LEN + (row % BLK) * ROW_LEN + (col % ROW_LEN);
    endfunction

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // One input transaction: read one pending pixel if there is one, then store a pushed pixel.
    function automatic void reorder_step(input t_in_item it);
        int unsigned w, h, pos, r, c, blk, base, wpix, col;
        logic [23:0] px, sp;
        t_out_item   res;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
        h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT_BLOCKS) ? MAX_HEIGHT_BLOCKS
                                                                       : height_reg);
        if (pixels_waiting != 0) begin
            pos  = rd_pos % (BLK * BLK);
            r    = pos / BLK;
            c    = pos % BLK;
            blk  = (rd_blk < w) ? rd_blk : 0;
            base = blk * BLK;
            px   = band_mem[store_addr(rd_half, r, base + c)];
            res  = '0;
            res.luma_out = px[7:0];
            // The top-left quadrant carries chroma of every second row and column.
            if (r < BLK / 2 && c < BLK / 2) begin
                sp = band_mem[store_addr(rd_half, 2 * r, base + 2 * c)];
                res.blue_diff_out = sp[15:8];
                res.red_diff_out  = sp[23:16];
            end
            res.block_end = (pos == BLK * BLK - 1);
            res.image_end = res.block_end && (blk == w - 1) && (band_idx == h - 1);
            expected_pixels = {expected_pixels, res};
            pixels_waiting--;
            if (res.block_end) begin
                rd_pos = 0;
                if (blk + 1 >= w) begin
                    rd_blk   = 0;
                    rd_half ^= 1;
                    band_idx = res.image_end ? 0 : (band_idx + 1) % 4096;
                end else begin
                    rd_blk = blk + 1;
                end
            end else begin
                rd_pos = pos + 1;
                rd_blk = blk;
            end
        end
        if (it.func == FUNC_PUSH) begin
            wpix = w * BLK;
            col  = (wr_col < wpix) ? wr_col : 0;
            band_mem[store_addr(wr_half, wr_row, col)] =
                {it.red_diff_in, it.blue_diff_in, it.luma_in};
            if (col + 1 >= wpix) begin
                wr_col = 0;
                if (wr_row + 1 >= BLK) begin
                    wr_row   = 0;
                    wr_half ^= 1;
                    pixels_waiting += wpix * BLK;
                    if (pixels_waiting > HALF_LEN) pixels_waiting = HALF_LEN;
                end else begin
                    wr_row++;
                end
            end else begin
                wr_col = col + 1;
            end
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            wr_col = 0; wr_row = 0; wr_half = 0;
            rd_blk = 0; rd_pos = 0; rd_half = 0;
            pixels_waiting = 0; band_idx = 0;
            width_reg  = 8'd1;
            height_reg = 13'd1;
            expected_pixels.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_WIDTH_IN_BLOCKS) width_reg = i_cfg_wdata[7:0];
                else height_reg = i_cfg_wdata[12:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    report($sformatf("unexpected result %h", i_out_data));
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_out_data.luma_out !== want.luma_out)
                        report($sformatf("luma_out %h, expected %h",
                                         i_out_data.luma_out, want.luma_out));
                    if (i_out_data.blue_diff_out !== want.blue_diff_out)
                        report($sformatf("blue_diff_out %h, expected %h",
                                         i_out_data.blue_diff_out, want.blue_diff_out));
                    if (i_out_data.red_diff_out !== want.red_diff_out)
                        report($sformatf("red_diff_out %h, expected %h",
                                         i_out_data.red_diff_out, want.red_diff_out));
                    if (i_out_data.block_end !== want.block_end)
                        report($sformatf("block_end %b, expected %b",
                                         i_out_data.block_end, want.block_end));
                    if (i_out_data.image_end !== want.image_end)
                        report($sformatf("image_end %b, expected %b",
                                         i_out_data.image_end, want.image_end));
                end
            end
            if (i_in_valid && i_in_ready) reorder_step(i_in_data);
        end
        o_outstanding <= expected_pixels.size();
    end

endmodule

// File: test/tb_raster_to_block_chroma_pack.sv
// Testbench top for raster_to_block_chroma_pack: clock, reset, stimulus, stalls and verdict.
// Depends on rbcp_pkg, the block itself and rbcp_block_order_checker.
`timescale 1ns / 1ps

module tb_raster_to_block_chroma_pack;
    import rbcp_pkg::*;

    // Cycles without any transaction before the run is declared hung. The longest
    // legitimate quiet stretch is the forced receiver hold-off plus a sender gap.
    localparam int STALL_LIMIT = 2000;
    // Settling time after the last expected result.
    localparam int SETTLE      = 4;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_wr_en = 1'b0;
    t_cfg_index            i_cfg_index = CFG_WIDTH_IN_BLOCKS;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    int fails;
    int outstanding;
    int idle_cycles = 0;
    int out_count   = 0;

    // Sender bookkeeping: pixels of finished bands that the block still holds, the fill
    // level of the band being written, and the length of the current burst.
    int unsigned undrained = 0;
    int unsigned band_fill = 0;
    int unsigned band_px   = 64;
    int          burst_left = 0;

    raster_to_block_chroma_pack dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    rbcp_block_order_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_data    (o_out_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fails),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Any transaction on either channel, or a register write, counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (o_out_valid && i_out_ready) out_count <= out_count + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("tb_raster_to_block_chroma_pack: done, errors");
        $finish;
    end

    // Receiver: a rotating random ready pattern, sometimes all ones so that long
    // stretches run without stalls. Twice, while the sender is busy, it holds ready
    // low for a long stretch so that the block's output stages fill and the input
    // channel has to stall.
    initial begin : receiver
        logic [15:0] pat;
        int          pat_left;
        int          hold_left;
        int          holds_done;
        int          hold_at;
        pat        = '1;
        pat_left   = 0;
        hold_left  = 0;
        holds_done = 0;
        hold_at    = 150;
        forever begin
            @(negedge i_clk);
            if (holds_done < 2 && out_count >= hold_at && i_in_valid) begin
                hold_left = 120;
                holds_done++;
                hold_at = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (pat_left == 0) begin
                    pat      = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
                    pat_left = 16;
                end
                i_out_ready <= pat[0];
                pat = {pat[0], pat[15:1]};
                pat_left--;
            end
        end
    end

    function automatic t_in_item rand_item(input t_func f);
        t_in_item it;
        it.func         = f;
        it.luma_in      = 8'($urandom);
        it.blue_diff_in = 8'($urandom);
        it.red_diff_in  = 8'($urandom);
        return it;
    endfunction

    // Offers one transaction and returns at the edge where it is accepted. Bursts of
    // random length are separated by random gaps; now and then a burst is long enough
    // to run a whole band without any idle cycle.
    task automatic send_item(input t_in_item it);
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(negedge i_clk);
            burst_left = ($urandom_range(3) == 0) ? 200 : $urandom_range(24, 1);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        // Every transaction reads one pending pixel; a push that completes a band
        // makes the whole band pending.
        if (undrained > 0) undrained--;
        if (it.func == FUNC_PUSH) begin
            band_fill++;
            if (band_fill == band_px) begin
                band_fill = 0;
                undrained += band_px;
            end
        end
    endtask

    // Waits until every predicted pixel has left the block, then lets the pipeline settle.
    task automatic wait_idle();
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input int unsigned value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= CFG_DATA_W'(value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // One phase: optionally program the image size, push whole bands mixed with drain
    // transactions, then drain until the block holds no finished pixel. Phases always
    // start on a band boundary, so a size change never leaves a half-written band.
    task automatic run_phase(input bit set_size, input int unsigned raw_w,
                             input int unsigned raw_h, input int bands,
                             input int drain_pct, input bit directed);
        logic [23:0] corner_pix [8];
        int unsigned w_eff;
        int unsigned pushes;
        int unsigned total;
        t_in_item    it;
        corner_pix = '{24'h000000, 24'hFFFFFF, 24'hAA55AA, 24'h55AA55,
                       24'h7F8001, 24'h807FFE, 24'h0000FF, 24'hFF0000};
        if (set_size) begin
            wait_idle();
            write_reg(CFG_WIDTH_IN_BLOCKS, raw_w);
            write_reg(CFG_HEIGHT_IN_BLOCKS, raw_h);
        end
        w_eff   = (raw_w == 0) ? 1 : ((raw_w > 128) ? 128 : raw_w);
        band_px = w_eff * 64;
        total   = bands * band_px;
        pushes  = 0;
        if (directed) begin
            // Drains while nothing is pending must produce no result.
            send_item('{FUNC_DRAIN, 8'hFF, 8'hFF, 8'hFF});
            send_item('{FUNC_DRAIN, 8'h00, 8'h00, 8'h00});
        end
        while (pushes < total) begin
            if ($urandom_range(99) < drain_pct) begin
                it = rand_item(FUNC_DRAIN);
            end else begin
                it = rand_item(FUNC_PUSH);
                // The first pixels of the run carry extreme and alternating values;
                // several land on the even rows and columns that feed the chroma.
                if (directed && pushes < 8) begin
                    {it.red_diff_in, it.blue_diff_in, it.luma_in} = corner_pix[pushes];
                end
                pushes++;
            end
            send_item(it);
        end
        while (undrained != 0) send_item(rand_item(FUNC_DRAIN));
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset sizes, then small images, clamped register values and a height change
        // at a band boundary in the middle of an image (five bands tall becomes three).
        run_phase(1'b0, 1, 1, 1, 20, 1'b1);
        run_phase(1'b1, 2, 1, 1, 10, 1'b0);
        run_phase(1'b1, 0, 0, 1, 30, 1'b0);
        run_phase(1'b1, 1, 5, 2, 0, 1'b0);
        run_phase(1'b1, 1, 3, 1, 25, 1'b0);
        // A height beyond the largest supported one is clamped.
        run_phase(1'b1, 1, 8191, 1, 5, 1'b0);

        wait_idle();
        if (fails == 0) begin
            $display("tb_raster_to_block_chroma_pack: done, clean");
        end else begin
            $display("tb_raster_to_block_chroma_pack: done, errors");
        end
        $finish;
    end

endmodule
